@@ rtl/core/hs_pkg.sv @@
`default_nettype none
package hs_pkg;

    localparam int KEY_BYTES_DEF = 32;
    localparam int CFG_IDX_W = 8;
    localparam int BUF_WORDS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 8'd3;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [31:0] OUTER_LEN = 32'd768;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_t;

    typedef struct packed {
        logic start;
        logic load_iv;
    } cmp_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_sts_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Word idx of the padded key block; key byte 0 sits in key[255:248].
    function automatic logic [31:0] key_pad_word(input logic [255:0] key,
                                                 input logic [3:0] idx,
                                                 input logic [7:0] pad,
                                                 input int nbytes);
        logic [31:0] w;
        logic [7:0]  kb;
        int          b;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            b = int'({idx, 2'b00}) + k;
            kb = (b < nbytes) ? key[8*(31-b) +: 8] : 8'h00;
            w[8*(3-k) +: 8] = kb ^ pad;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/hmac_sha256_engine.sv @@
`default_nettype none
// HMAC-SHA256 engine. Load the key into the four key registers (first key byte in bits 63:56 of
// key register 0; bytes at or past KEY_BYTES are taken as zero) while the engine is idle, then
// send the message one byte per item with last_byte set on the final byte; the four 64-bit
// digest words follow in order, word 0 first, with last_word set on word 3. A message byte is
// stored before the next byte is taken; every 64 bytes one more SHA-256 block runs through the
// single round unit at one round per cycle, and no byte is taken meanwhile.
// The first byte of a message adds one key block, and the last byte adds padding at one byte a
// cycle, one or two padded blocks, the outer key block and the outer digest block before the
// first digest word appears. Message words are held in a 16-entry buffer memory that the round
// unit reads one word per round; the byte path and the round unit never use it at the same
// time. The configuration port always accepts; writes to indexes past the key registers are
// ignored.
module hmac_sha256_engine #(
    parameter int KEY_BYTES = hs_pkg::KEY_BYTES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire hs_pkg::in_t                  s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output hs_pkg::out_t                      m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [hs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                  cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KEYC = 4'd1;
    localparam logic [3:0] S_BYTE = 4'd2;
    localparam logic [3:0] S_MSGC = 4'd3;
    localparam logic [3:0] S_PAD  = 4'd4;
    localparam logic [3:0] S_PADC = 4'd5;
    localparam logic [3:0] S_OKEY = 4'd6;
    localparam logic [3:0] S_OMSG = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [1:0] SRC_IPAD  = 2'd0;
    localparam logic [1:0] SRC_BUF   = 2'd1;
    localparam logic [1:0] SRC_OPAD  = 2'd2;
    localparam logic [1:0] SRC_OUTER = 2'd3;

    logic [3:0]   state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic         absorbed_reg, absorbed_next;
    logic         pad_start_reg, pad_start_next;
    logic         len_mode_reg, len_mode_next;
    logic         len_done_reg, len_done_next;
    logic [1:0]   src_reg, src_next;
    logic [1:0]   out_cnt_reg, out_cnt_next;
    logic [23:0]  acc_reg;
    logic [63:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]   byte_reg;
    logic         last_reg;
    logic [31:0]  w_q_reg;
    logic [255:0] inner_reg;
    logic [63:0]  key_reg [4];
    logic [255:0] key_flat;

    logic             wr_en;
    logic [7:0]       wr_byte;
    logic [7:0]       pad_byte;
    logic             len_now;
    logic             ram_we;
    logic [31:0]      ram_rdata;
    logic [31:0]      w_in;
    logic [31:0]      outer_word;
    logic [3:0]       rd_idx;
    logic [255:0]     hash;
    logic             capture;
    hs_pkg::cmp_ctl_t cmp_ctl;
    hs_pkg::cmp_sts_t cmp_sts;

    assign key_flat = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data.digest_word = hash[{~out_cnt_reg, 6'b0} +: 64];
    assign m_data.word_index = out_cnt_reg;
    assign m_data.last_word = (out_cnt_reg == 2'd3);

    // Padding after the 0x80 marker is zeros until byte 56 of a block, then the length.
    assign len_now = len_mode_reg || (pad_start_reg && fill_reg == 6'd56);
    always_comb begin
        if (!pad_start_reg) begin
            pad_byte = hs_pkg::PAD_MARK;
        end else if (len_now) begin
            pad_byte = bit_cnt_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // The outer message block is the inner digest, the marker and a fixed length of 768 bits.
    always_comb begin
        if (rd_idx[3] == 1'b0) begin
            outer_word = inner_reg[32*(7 - int'(rd_idx[2:0])) +: 32];
        end else if (rd_idx == 4'd8) begin
            outer_word = {hs_pkg::PAD_MARK, 24'h0};
        end else if (rd_idx == 4'd15) begin
            outer_word = hs_pkg::OUTER_LEN;
        end else begin
            outer_word = 32'h0;
        end
    end

    assign w_in = (src_reg == SRC_BUF) ? ram_rdata : w_q_reg;
    assign ram_we = wr_en && (fill_reg[1:0] == 2'b11);

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg;
        absorbed_next = absorbed_reg;
        pad_start_next = pad_start_reg;
        len_mode_next = len_mode_reg;
        len_done_next = len_done_reg;
        src_next = src_reg;
        out_cnt_next = out_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        wr_en = 1'b0;
        wr_byte = byte_reg;
        capture = 1'b0;
        cmp_ctl = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!absorbed_reg) begin
                        // The inner key block starts a new message.
                        cmp_ctl.start = 1'b1;
                        cmp_ctl.load_iv = 1'b1;
                        src_next = SRC_IPAD;
                        absorbed_next = 1'b1;
                        bit_cnt_next = 64'd512;
                        state_next = S_KEYC;
                    end else begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_KEYC: begin
                if (cmp_sts.done) begin
                    state_next = S_BYTE;
                end
            end
            S_BYTE: begin
                wr_en = 1'b1;
                fill_next = fill_reg + 6'd1;
                bit_cnt_next = bit_cnt_reg + 64'd8;
                if (fill_reg == 6'd63) begin
                    cmp_ctl.start = 1'b1;
                    src_next = SRC_BUF;
                    state_next = S_MSGC;
                end else if (last_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MSGC: begin
                if (cmp_sts.done) begin
                    state_next = last_reg ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                wr_en = 1'b1;
                wr_byte = pad_byte;
                fill_next = fill_reg + 6'd1;
                pad_start_next = 1'b1;
                len_mode_next = len_now;
                if (fill_reg == 6'd63) begin
                    len_done_next = len_now;
                    cmp_ctl.start = 1'b1;
                    src_next = SRC_BUF;
                    state_next = S_PADC;
                end
            end
            S_PADC: begin
                if (cmp_sts.done) begin
                    if (len_done_reg) begin
                        capture = 1'b1;
                        cmp_ctl.start = 1'b1;
                        cmp_ctl.load_iv = 1'b1;
                        src_next = SRC_OPAD;
                        state_next = S_OKEY;
                    end else begin
                        state_next = S_PAD;
                    end
                end
            end
            S_OKEY: begin
                if (cmp_sts.done) begin
                    cmp_ctl.start = 1'b1;
                    src_next = SRC_OUTER;
                    state_next = S_OMSG;
                end
            end
            S_OMSG: begin
                if (cmp_sts.done) begin
                    out_cnt_next = 2'd0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    out_cnt_next = out_cnt_reg + 2'd1;
                    if (out_cnt_reg == 2'd3) begin
                        // Back to idle with the message state cleared for the next message; the key is kept.
                        absorbed_next = 1'b0;
                        fill_next = '0;
                        pad_start_next = 1'b0;
                        len_mode_next = 1'b0;
                        len_done_next = 1'b0;
                        cmp_ctl.start = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            absorbed_reg <= 1'b0;
            pad_start_reg <= 1'b0;
            len_mode_reg <= 1'b0;
            len_done_reg <= 1'b0;
            src_reg <= SRC_IPAD;
            out_cnt_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            absorbed_reg <= absorbed_next;
            pad_start_reg <= pad_start_next;
            len_mode_reg <= len_mode_next;
            len_done_reg <= len_done_next;
            src_reg <= src_next;
            out_cnt_reg <= out_cnt_next;
            if (cfg_valid) begin
                case (cfg_index)
                    hs_pkg::REG_KEY_0: key_reg[0] <= cfg_data;
                    hs_pkg::REG_KEY_1: key_reg[1] <= cfg_data;
                    hs_pkg::REG_KEY_2: key_reg[2] <= cfg_data;
                    hs_pkg::REG_KEY_3: key_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        bit_cnt_reg <= bit_cnt_next;
        if (s_valid && s_ready) begin
            byte_reg <= s_data.message_byte;
            last_reg <= s_data.last_byte;
        end
        if (wr_en) begin
            acc_reg <= {acc_reg[15:0], wr_byte};
        end
        if (capture) begin
            inner_reg <= hash;
        end
        case (src_reg)
            SRC_IPAD:  w_q_reg <= hs_pkg::key_pad_word(key_flat, rd_idx, hs_pkg::IPAD, KEY_BYTES);
            SRC_OPAD:  w_q_reg <= hs_pkg::key_pad_word(key_flat, rd_idx, hs_pkg::OPAD, KEY_BYTES);
            SRC_OUTER: w_q_reg <= outer_word;
            default:   w_q_reg <= ram_rdata;
        endcase
    end

    hs_ram #(
        .WIDTH(32),
        .DEPTH(hs_pkg::BUF_WORDS)
    ) u_buf (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(fill_reg[5:2]),
        .wdata({acc_reg, wr_byte}),
        .raddr(rd_idx),
        .rdata(ram_rdata)
    );

    hs_compress u_cmp (
        .clk   (aclk),
        .rstn  (aresetn),
        .ctl   (cmp_ctl),
        .w_in  (w_in),
        .rd_idx(rd_idx),
        .sts   (cmp_sts),
        .hash  (hash)
    );

`ifndef SYNTHESIS
    // The input side and the digest side are never open together.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input ready while digest pending");
    // A block is started only on an idle round unit.
    assert property (@(posedge aclk) disable iff (!aresetn) cmp_ctl.start |-> !cmp_sts.busy)
        else $error("round unit restarted while busy");
    // The buffer is never written while the round unit may read it.
    assert property (@(posedge aclk) disable iff (!aresetn) ram_we |-> !cmp_sts.busy)
        else $error("buffer written during compression");
    // After the final digest word the engine waits for a new message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=> (s_ready && !absorbed_reg))
        else $error("engine not idle after digest");
`endif
endmodule
`default_nettype wire

@@ rtl/core/hs_ram.sv @@
`default_nettype none
module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/hs_compress.sv @@
`default_nettype none
module hs_compress (
    input  wire logic             clk,
    input  wire logic             rstn,
    input  wire hs_pkg::cmp_ctl_t ctl,
    input  wire logic [31:0]      w_in,
    output logic      [3:0]       rd_idx,
    output hs_pkg::cmp_sts_t      sts,
    output logic      [255:0]     hash
);
    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_PRE  = 2'd1;
    localparam logic [1:0] P_RND  = 2'd2;
    localparam logic [1:0] P_ADD  = 2'd3;

    logic [1:0]  phase_reg;
    logic [5:0]  t_reg;
    logic        done_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] win_reg [16];
    logic [31:0] w_t, t1, t2, ch, mj;

    // The first sixteen words come from w_in; later ones from the window.
    always_comb begin
        if (t_reg[5:4] == 2'b00) begin
            w_t = w_in;
        end else begin
            w_t = hs_pkg::ssig1(win_reg[14]) + win_reg[9]
                + hs_pkg::ssig0(win_reg[1]) + win_reg[0];
        end
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + hs_pkg::bsig1(v_reg[4]) + ch + hs_pkg::ROUND_K[t_reg] + w_t;
        t2 = hs_pkg::bsig0(v_reg[0]) + mj;
        rd_idx = (phase_reg == P_RND) ? t_reg[3:0] + 4'd1 : 4'd0;
        for (int i = 0; i < 8; i++) begin
            hash[32*(7-i) +: 32] = h_reg[i];
        end
    end

    assign sts.busy = (phase_reg != P_IDLE);
    assign sts.done = done_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg <= P_IDLE;
            t_reg <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= hs_pkg::INIT_HASH[i];
            end
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE: begin
                    if (ctl.start) begin
                        phase_reg <= P_PRE;
                        if (ctl.load_iv) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= hs_pkg::INIT_HASH[i];
                            end
                        end
                    end
                end
                P_PRE: begin
                    t_reg <= '0;
                    phase_reg <= P_RND;
                end
                P_RND: begin
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63) begin
                        phase_reg <= P_ADD;
                    end
                end
                P_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    done_reg <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (phase_reg == P_PRE) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (phase_reg == P_RND) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_t;
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_hmac_sha256_engine.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_hmac_sha256_engine;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 400;
    localparam int LONG_HOLD = 900;
    localparam int PHASE_BYTES = 32;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    hs_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    hs_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [hs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // Bytes waiting for the driver, and the digest words the predictor says will come out.
    hs_pkg::in_t byte_q[$];
    hs_pkg::out_t digest_q[$];
    int errors = 0;

    // Steering from the stimulus process: no_gaps turns idling off on both sides, and
    // hold_armed asks the receiver for one long hold-off.
    bit no_gaps = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // Predictor state: running hash, the partial block, its fill level and the bit count.
    logic [63:0] key_shadow[4] = '{default: '0};
    logic [31:0] run_hash[8];
    logic [7:0] part_block[64];
    int part_fill = 0;
    logic [63:0] bits_done = '0;
    bit in_message = 1'b0;

    hmac_sha256_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One SHA-256 compression of part_block into run_hash.
    function automatic void compress_part();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {part_block[4*t], part_block[4*t+1], part_block[4*t+2], part_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        {a, b, c, d, e, f, g, h} = {run_hash[0], run_hash[1], run_hash[2], run_hash[3],
                                    run_hash[4], run_hash[5], run_hash[6], run_hash[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + hs_pkg::ROUND_K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
        run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
    endfunction

    // Restart the hash and absorb the zero-padded key XOR pad.
    function automatic void absorb_key(logic [7:0] pad);
        logic [7:0] kb;
        run_hash = hs_pkg::INIT_HASH;
        for (int i = 0; i < 64; i++) begin
            kb = (i < 32) ? key_shadow[i/8][63 - 8*(i%8) -: 8] : 8'h00;
            part_block[i] = kb ^ pad;
        end
        compress_part();
        bits_done = 64'd512;
        part_fill = 0;
    endfunction

    function automatic void put_length(logic [63:0] nbits);
        for (int j = 0; j < 8; j++)
            part_block[56 + j] = nbits[63 - 8*j -: 8];
    endfunction

    // Advance the predicted engine by one accepted byte; a last byte yields four digest words.
    function automatic void hmac_take_byte(hs_pkg::in_t item);
        logic [31:0] inner[8];
        int i;
        hs_pkg::out_t word;
        if (!in_message) begin
            absorb_key(hs_pkg::IPAD);
            in_message = 1'b1;
        end
        part_block[part_fill] = item.message_byte;
        part_fill++;
        if (part_fill == 64) begin
            compress_part();
            bits_done += 64'd512;
            part_fill = 0;
        end
        if (!item.last_byte) return;
        // Close the inner hash; the length field may push padding into a second block.
        bits_done += 64'(part_fill * 8);
        i = part_fill;
        part_block[i++] = hs_pkg::PAD_MARK;
        if (i > 56) begin
            while (i < 64) part_block[i++] = 8'h00;
            compress_part();
            i = 0;
        end
        while (i < 56) part_block[i++] = 8'h00;
        put_length(bits_done);
        compress_part();
        inner = run_hash;
        // Outer hash over the opad block and the 32-byte inner digest.
        absorb_key(hs_pkg::OPAD);
        for (int k = 0; k < 32; k++)
            part_block[k] = inner[k/4][31 - 8*(k%4) -: 8];
        part_block[32] = hs_pkg::PAD_MARK;
        for (int k = 33; k < 56; k++) part_block[k] = 8'h00;
        put_length(bits_done + 64'd256);
        compress_part();
        for (int k = 0; k < 4; k++) begin
            word.digest_word = {run_hash[2*k], run_hash[2*k+1]};
            word.word_index = 2'(k);
            word.last_word = (k == 3);
            digest_q.push_back(word);
        end
        run_hash = hs_pkg::INIT_HASH;
        part_fill = 0;
        bits_done = '0;
        in_message = 1'b0;
    endfunction

    // Byte driver: a new item is offered only when the previous one has gone or none is up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                hmac_take_byte(s_data);
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && (no_gaps || $urandom_range(99) >= 11)) begin
                    s_valid <= 1'b1;
                    s_data <= byte_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Digest monitor: checks each accepted word against the oldest prediction and
    // drives m_ready, including the one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h", m_data.digest_word);
                    errors++;
                end else begin
                    hs_pkg::out_t want;
                    want = digest_q.pop_front();
                    if (m_data.digest_word !== want.digest_word) begin
                        $error("digest_word: expected %h, got %h",
                               want.digest_word, m_data.digest_word);
                        errors++;
                    end
                    if (m_data.word_index !== want.word_index) begin
                        $error("word_index: expected %0d, got %0d",
                               want.word_index, m_data.word_index);
                        errors++;
                    end
                    if (m_data.last_word !== want.last_word) begin
                        $error("last_word: expected %0d, got %0d",
                               want.last_word, m_data.last_word);
                        errors++;
                    end
                end
            end
            if (hold_armed && !hold_done && m_valid) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_gaps || $urandom_range(99) >= 11;
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_key(logic [hs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_shadow[idx[1:0]] = value;
    endtask

    task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
        write_key(hs_pkg::REG_KEY_0, k0);
        write_key(hs_pkg::REG_KEY_1, k1);
        write_key(hs_pkg::REG_KEY_2, k2);
        write_key(hs_pkg::REG_KEY_3, k3);
    endtask

    task automatic queue_fixed(logic [7:0] b, bit last);
        hs_pkg::in_t item;
        item.message_byte = b;
        item.last_byte = last;
        byte_q.push_back(item);
    endtask

    task automatic queue_random_message(int len);
        for (int k = 0; k < len; k++)
            queue_fixed(8'($urandom), k == len - 1);
    endtask

    // Pick a message length: mostly short, sometimes one that lands on a padding boundary.
    function automatic int pick_length();
        int edges[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        if ($urandom_range(99) < 75) return $urandom_range(1, 12);
        return edges[$urandom_range(7)];
    endfunction

    // Wait until the engine has drained everything the driver handed it.
    task automatic drain();
        do @(posedge aclk); while (byte_q.size() != 0 || s_valid || digest_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int len;
        run_hash = hs_pkg::INIT_HASH;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: the all-zero reset key, single-byte messages at both byte extremes, then a three-byte one.
        queue_fixed(8'h00, 1'b1);
        queue_fixed(8'hff, 1'b1);
        queue_fixed(8'h61, 1'b0);
        queue_fixed(8'h62, 1'b0);
        queue_fixed(8'h63, 1'b1);
        drain();

        // Directed: the all-ones key, then a key whose last word is zero.
        load_key('1, '1, '1, '1);
        queue_fixed(8'hff, 1'b1);
        queue_fixed(8'h00, 1'b0);
        queue_fixed(8'h80, 1'b0);
        queue_fixed(8'h7f, 1'b1);
        drain();
        load_key(64'h0b0b0b0b0b0b0b0b, 64'h0b0b0b0b0b0b0b0b, 64'h0b0b0b0b00000000, '0);
        queue_fixed(8'h48, 1'b0);
        queue_fixed(8'h69, 1'b1);
        queue_random_message(3);
        drain();

        // Random phases with random keys; one runs without gaps, one holds the receiver off.
        for (int ph = 0; ph < 4; ph++) begin
            load_key({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            no_gaps = (ph == 1);
            hold_armed = (ph == 2);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                len = pick_length();
                // Only the first message of a phase may run past the phase budget.
                if (sent != 0 && len > PHASE_BYTES - sent) len = PHASE_BYTES - sent;
                queue_random_message(len);
                sent += len;
            end
            drain();
        end
        no_gaps = 1'b0;

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/hs_pkg.sv
rtl/core/hs_ram.sv
rtl/core/hs_compress.sv
rtl/core/hmac_sha256_engine.sv
tb/tb_hmac_sha256_engine.sv
